### hdl/cfb_pkg.sv
// Package for the checksummed frame builder.
// Holds command and result types, status and kind codes and fixed constants.
// No dependencies.
package cfb_pkg;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_TOO_LONG     = 2'd1;
  localparam logic [1:0] ST_NOT_OPEN     = 2'd2;
  localparam logic [1:0] ST_ALREADY_OPEN = 2'd3;

  localparam logic [1:0] KIND_REJECT = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;

  localparam int FRAME_OVERHEAD = 5;

  localparam int          CFG_IDX_W      = 2;
  localparam logic [1:0]  CFG_HDR_FIRST  = 2'd0;
  localparam logic [1:0]  CFG_HDR_SECOND = 2'd1;
  localparam logic [7:0]  HDR_FIRST_RST  = 8'd170;
  localparam logic [7:0]  HDR_SECOND_RST = 8'd85;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  // result index within one command: header, header, length, type, checksum
  localparam int          IDX_W       = 3;
  localparam logic [2:0]  IDX_HDR_1   = 3'd0;
  localparam logic [2:0]  IDX_HDR_2   = 3'd1;
  localparam logic [2:0]  IDX_LEN     = 3'd2;
  localparam logic [2:0]  IDX_TYPE    = 3'd3;
  localparam logic [2:0]  IDX_PAYLOAD = 3'd0;

  typedef struct packed {
    logic [1:0] kind;
    logic       close;   // checksum byte follows
    logic [1:0] status;
    logic [7:0] len;
    logic [7:0] dat;     // frame type for a start, payload byte otherwise
    logic [7:0] sum;
  } cmd_t;

  typedef struct packed {
    logic [7:0] obyte;
    logic       valid;
    logic [1:0] status;
    logic       frame_end;
    logic       run_last;
  } result_t;

endpackage

### hdl/cfb_front.sv
// Front end of the frame builder: accepts requests, tracks the open frame
// and the running sum, and issues one command per request.
// Depends on cfb_pkg.
module cfb_front #(
  parameter int FRAME_BUFFER_BYTES = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  logic          in_func,
  input  logic [7:0]    in_frame_type,
  input  logic [7:0]    in_frame_length,
  input  logic [7:0]    in_data_byte,
  input  logic          q_full,
  output logic          cmd_push,
  output cfb_pkg::cmd_t cmd
);

  logic       open_r, open_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [8:0] need;
  logic       too_long;

  assign cmd_push = in_push && !q_full;
  assign need     = {1'b0, in_frame_length} + 9'(cfb_pkg::FRAME_OVERHEAD);
  assign too_long = need > 9'(FRAME_BUFFER_BYTES);

  always_comb begin
    open_nxt   = open_r;
    left_nxt   = left_r;
    sum_nxt    = sum_r;
    cmd.kind   = cfb_pkg::KIND_REJECT;
    cmd.close  = 1'b0;
    cmd.status = cfb_pkg::ST_OK;
    cmd.len    = in_frame_length;
    cmd.dat    = in_data_byte;
    cmd.sum    = sum_r;
    if (in_func == cfb_pkg::FUNC_START) begin
      cmd.dat = in_frame_type;
      if (open_r) begin
        cmd.status = cfb_pkg::ST_ALREADY_OPEN;
      end else if (too_long) begin
        cmd.status = cfb_pkg::ST_TOO_LONG;
      end else begin
        cmd.kind  = cfb_pkg::KIND_START;
        sum_nxt   = in_frame_length + in_frame_type;
        cmd.sum   = sum_nxt;
        cmd.close = (in_frame_length == 8'd0);
        open_nxt  = (in_frame_length != 8'd0);
        left_nxt  = in_frame_length;
      end
    end else begin
      if (!open_r) begin
        cmd.status = cfb_pkg::ST_NOT_OPEN;
      end else begin
        cmd.kind  = cfb_pkg::KIND_DATA;
        sum_nxt   = sum_r + in_data_byte;
        cmd.sum   = sum_nxt;
        left_nxt  = left_r - 8'd1;
        cmd.close = (left_r == 8'd1);
        open_nxt  = (left_r != 8'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      left_r <= 8'd0;
      sum_r  <= 8'd0;
    end else if (cmd_push) begin
      open_r <= open_nxt;
      left_r <= left_nxt;
      sum_r  <= sum_nxt;
    end
  end

endmodule

### hdl/cfb_cmd_q.sv
// Short command queue between front and back end of the frame builder.
// Depends on cfb_pkg.
module cfb_cmd_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cfb_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output cfb_pkg::cmd_t head
);

  cfb_pkg::cmd_t mem_r [cfb_pkg::CMDQ_DEPTH];
  logic [cfb_pkg::CMDQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [cfb_pkg::CMDQ_PTR_W:0]   count_r;
  logic do_push, do_pop;

  assign full    = (count_r == (cfb_pkg::CMDQ_PTR_W+1)'(cfb_pkg::CMDQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

### hdl/cfb_back.sv
// Back end of the frame builder: expands each command into frame bytes,
// one per cycle while the output register is free or popped, into that register.
// Depends on cfb_pkg.
module cfb_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            hdr_first,
  input  logic [7:0]            hdr_second,
  input  logic                  q_empty,
  input  cfb_pkg::cmd_t         head,
  output logic                  q_pop,
  input  logic                  out_pop,
  output logic                  out_empty,
  output cfb_pkg::result_t      res_out
);

  logic [cfb_pkg::IDX_W-1:0] idx_r;
  logic                      out_valid_r;
  cfb_pkg::result_t          res_r, res;
  logic                      load;

  always_comb begin
    res.obyte     = 8'd0;
    res.valid     = 1'b1;
    res.status    = cfb_pkg::ST_OK;
    res.frame_end = 1'b0;
    res.run_last  = 1'b0;
    unique case (head.kind)
      cfb_pkg::KIND_START: begin
        case (idx_r)
          cfb_pkg::IDX_HDR_1: res.obyte = hdr_first;
          cfb_pkg::IDX_HDR_2: res.obyte = hdr_second;
          cfb_pkg::IDX_LEN:   res.obyte = head.len;
          cfb_pkg::IDX_TYPE: begin
            res.obyte    = head.dat;
            res.run_last = !head.close;
          end
          default: begin
            res.obyte     = head.sum;
            res.frame_end = 1'b1;
            res.run_last  = 1'b1;
          end
        endcase
      end
      cfb_pkg::KIND_DATA: begin
        if (idx_r == cfb_pkg::IDX_PAYLOAD) begin
          res.obyte    = head.dat;
          res.run_last = !head.close;
        end else begin
          res.obyte     = head.sum;
          res.frame_end = 1'b1;
          res.run_last  = 1'b1;
        end
      end
      default: begin
        // rejection: single result carrying the status
        res.valid    = 1'b0;
        res.status   = head.status;
        res.run_last = 1'b1;
      end
    endcase
  end

  assign load      = !q_empty && (!out_valid_r || out_pop);
  assign q_pop     = load && res.run_last;
  assign out_empty = !out_valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= q_pop ? '0 : idx_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### hdl/checksummed_frame_builder.sv
// Checksummed frame builder: header bytes, length, type, payload and an
// 8-bit wrapping checksum, produced as a byte queue. Depends on cfb_pkg,
// cfb_front, cfb_cmd_q and cfb_back.
//
// A request is taken while the command queue has room and is classified by
// the front end, which queues one command in a two-entry queue. The back end
// emits one result byte per cycle through a single output register while that
// register is free or popped, so a payload request yields one result (two when
// it closes the frame), a start four or five and a rejection one. Requests keep
// flowing while results wait, until the command queue fills. Header bytes are read
// when emitted; write them only while the block is idle. No clearing pass.
module checksummed_frame_builder #(
  parameter int FRAME_BUFFER_BYTES = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_func,
  input  logic [7:0]                     in_frame_type,
  input  logic [7:0]                     in_frame_length,
  input  logic [7:0]                     in_data_byte,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [7:0]                     out_byte,
  output logic                           out_byte_valid,
  output logic [1:0]                     out_status,
  output logic                           out_frame_end,
  output logic                           out_run_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data
);

  logic [7:0]       hdr_first_r, hdr_second_r;
  logic             q_full, q_empty, q_pop, cmd_push;
  cfb_pkg::cmd_t    cmd, head;
  cfb_pkg::result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= cfb_pkg::HDR_FIRST_RST;
      hdr_second_r <= cfb_pkg::HDR_SECOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == cfb_pkg::CFG_HDR_FIRST)  hdr_first_r  <= cfg_data;
      if (cfg_index == cfb_pkg::CFG_HDR_SECOND) hdr_second_r <= cfg_data;
    end
  end

  assign in_full = q_full;

  cfb_front #(.FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_func        (in_func),
    .in_frame_type  (in_frame_type),
    .in_frame_length(in_frame_length),
    .in_data_byte   (in_data_byte),
    .q_full         (q_full),
    .cmd_push       (cmd_push),
    .cmd            (cmd)
  );

  cfb_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_data(cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head)
  );

  cfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .hdr_first (hdr_first_r),
    .hdr_second(hdr_second_r),
    .q_empty   (q_empty),
    .head      (head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .res_out   (res)
  );

  assign out_byte       = res.obyte;
  assign out_byte_valid = res.valid;
  assign out_status     = res.status;
  assign out_frame_end  = res.frame_end;
  assign out_run_last   = res.run_last;

`ifndef SYNTHESIS
  a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_byte_valid) |-> out_run_last)
    else $error("rejection result not marked last");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_frame_end) |-> (out_run_last && out_byte_valid))
    else $error("checksum byte not last or not valid");

  a_status_ok_on_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_byte_valid) |-> (out_status == cfb_pkg::ST_OK))
    else $error("frame byte with error status");
`endif

endmodule

### bench/cfb_frame_checker.sv
// Scoreboard for the checksummed frame builder: watches the request, result
// and header-write channels, predicts every frame byte and compares it.
// Depends on cfb_pkg.
module cfb_frame_checker #(
  parameter int BUFFER_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic                          in_full,
  input  logic                          in_func,
  input  logic [7:0]                    in_frame_type,
  input  logic [7:0]                    in_frame_length,
  input  logic [7:0]                    in_data_byte,
  input  logic                          out_empty,
  input  logic                          out_pop,
  input  logic [7:0]                    out_byte,
  input  logic                          out_byte_valid,
  input  logic [1:0]                    out_status,
  input  logic                          out_frame_end,
  input  logic                          out_run_last,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [cfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]       hdr_first;
  logic [7:0]       hdr_second;
  logic             frame_is_open;
  logic [7:0]       payload_left;
  logic [7:0]       frame_sum;
  cfb_pkg::result_t expected_bytes[$];

  function automatic void queue_result(logic [7:0] obyte, logic valid, logic [1:0] status,
                                       logic frame_end, logic run_last);
    cfb_pkg::result_t r;
    r.obyte     = obyte;
    r.valid     = valid;
    r.status    = status;
    r.frame_end = frame_end;
    r.run_last  = run_last;
    expected_bytes.push_back(r);
  endfunction

  function automatic void predict_frame_bytes(logic func, logic [7:0] ftype,
                                              logic [7:0] flen, logic [7:0] dbyte);
    if (func == cfb_pkg::FUNC_START) begin
      // an open frame wins over the length test
      if (frame_is_open) begin
        queue_result(8'd0, 1'b0, cfb_pkg::ST_ALREADY_OPEN, 1'b0, 1'b1);
      end else if (int'(flen) + cfb_pkg::FRAME_OVERHEAD > BUFFER_BYTES) begin
        queue_result(8'd0, 1'b0, cfb_pkg::ST_TOO_LONG, 1'b0, 1'b1);
      end else begin
        frame_sum = flen + ftype;
        queue_result(hdr_first, 1'b1, cfb_pkg::ST_OK, 1'b0, 1'b0);
        queue_result(hdr_second, 1'b1, cfb_pkg::ST_OK, 1'b0, 1'b0);
        queue_result(flen, 1'b1, cfb_pkg::ST_OK, 1'b0, 1'b0);
        if (flen == 8'd0) begin
          // empty payload: checksum follows the type byte at once
          queue_result(ftype, 1'b1, cfb_pkg::ST_OK, 1'b0, 1'b0);
          queue_result(frame_sum, 1'b1, cfb_pkg::ST_OK, 1'b1, 1'b1);
        end else begin
          queue_result(ftype, 1'b1, cfb_pkg::ST_OK, 1'b0, 1'b1);
          frame_is_open = 1'b1;
          payload_left  = flen;
        end
      end
    end else if (!frame_is_open) begin
      queue_result(8'd0, 1'b0, cfb_pkg::ST_NOT_OPEN, 1'b0, 1'b1);
    end else begin
      frame_sum    = frame_sum + dbyte;
      payload_left = payload_left - 8'd1;
      if (payload_left == 8'd0) begin
        queue_result(dbyte, 1'b1, cfb_pkg::ST_OK, 1'b0, 1'b0);
        queue_result(frame_sum, 1'b1, cfb_pkg::ST_OK, 1'b1, 1'b1);
        frame_is_open = 1'b0;
      end else begin
        queue_result(dbyte, 1'b1, cfb_pkg::ST_OK, 1'b0, 1'b1);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    cfb_pkg::result_t want;
    if (!rst_n) begin
      hdr_first     = cfb_pkg::HDR_FIRST_RST;
      hdr_second    = cfb_pkg::HDR_SECOND_RST;
      frame_is_open = 1'b0;
      payload_left  = 8'd0;
      frame_sum     = 8'd0;
      expected_bytes.delete();
    end else begin
      // compare first: a request taken at this edge cannot have a result out yet
      if (out_pop && !out_empty) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: out_byte %0d, status %0d", out_byte, out_status);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("out_byte", want.obyte, out_byte);
          check_field("out_byte_valid", want.valid, out_byte_valid);
          check_field("out_status", want.status, out_status);
          check_field("out_frame_end", want.frame_end, out_frame_end);
          check_field("out_run_last", want.run_last, out_run_last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cfb_pkg::CFG_HDR_FIRST:  hdr_first = cfg_data;
          cfb_pkg::CFG_HDR_SECOND: hdr_second = cfg_data;
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        predict_frame_bytes(in_func, in_frame_type, in_frame_length, in_data_byte);
      end
    end
    pending = expected_bytes.size();
  end

endmodule

### bench/checksummed_frame_builder_tb.sv
// Top of the frame builder bench: clock, reset, request and header stimulus,
// random result draining and the verdict. Depends on cfb_pkg, cfb_frame_checker
// and the checksummed_frame_builder RTL.
module checksummed_frame_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUFFER_BYTES   = 256;
  localparam int MAX_WAIT       = 10;
  localparam int SETTLE_CYCLES  = 16;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS    = 60;

  logic                          clk;
  logic                          rst_n;
  logic                          in_push;
  logic                          in_full;
  logic                          in_func;
  logic [7:0]                    in_frame_type;
  logic [7:0]                    in_frame_length;
  logic [7:0]                    in_data_byte;
  logic                          out_empty;
  logic                          out_pop;
  logic [7:0]                    out_byte;
  logic                          out_byte_valid;
  logic [1:0]                    out_status;
  logic                          out_frame_end;
  logic                          out_run_last;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [cfb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                    cfg_data;

  int fail_count;
  int pending;
  int items_sent;
  int hold_requests;
  bit tx_idle_on;
  bit rx_idle_on;

  checksummed_frame_builder #(.FRAME_BUFFER_BYTES(BUFFER_BYTES)) dut (.*);

  cfb_frame_checker #(.BUFFER_BYTES(BUFFER_BYTES)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one request; hold it until taken. Leaves time at a falling edge.
  task automatic send_request(input logic func, input logic [7:0] ftype,
                              input logic [7:0] flen, input logic [7:0] dbyte);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push         <= 1'b1;
    in_func         <= func;
    in_frame_type   <= ftype;
    in_frame_length <= flen;
    in_data_byte    <= dbyte;
    do @(posedge clk); while (in_full);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_start(input int len);
    send_request(cfb_pkg::FUNC_START, 8'($urandom_range(0, 255)), 8'(len),
                 8'($urandom_range(0, 255)));
  endtask

  task automatic send_payload();
    send_request(cfb_pkg::FUNC_DATA, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Drop the request line and wait until every frame byte has been drained.
  task automatic wait_drained();
    in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_headers(input logic [7:0] first, input logic [7:0] second);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= cfb_pkg::CFG_HDR_FIRST;
    cfg_data  <= first;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= cfb_pkg::CFG_HDR_SECOND;
    cfg_data  <= second;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly complete frames; the rest stray payload, oversize starts and
  // frames interrupted by a second start.
  task automatic send_random_unit();
    int pick;
    int len;
    int cut;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      send_start(len);
      repeat (len) send_payload();
    end else if (pick < 83) begin
      send_payload();
    end else if (pick < 90) begin
      send_start($urandom_range(252, 255));
    end else begin
      len = $urandom_range(1, 6);
      cut = $urandom_range(0, len - 1);
      send_start(len);
      repeat (cut) send_payload();
      send_start($urandom_range(0, 255));
      repeat (len - cut) send_payload();
    end
  endtask

  task automatic run_phase();
    int target;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) send_random_unit();
  endtask

  initial begin : result_drain
    int stall;
    int holds_served;
    out_pop      = 1'b0;
    holds_served = 0;
    @(negedge clk);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        stall        = RX_HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_func         = cfb_pkg::FUNC_START;
    in_frame_type   = 8'd0;
    in_frame_length = 8'd0;
    in_data_byte    = 8'd0;
    cfg_valid       = 1'b0;
    cfg_index       = cfb_pkg::CFG_HDR_FIRST;
    cfg_data        = 8'd0;
    items_sent      = 0;
    hold_requests   = 0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed part, reset header values
    send_request(cfb_pkg::FUNC_DATA, 8'h00, 8'h00, 8'hFF);   // payload, no frame open
    send_request(cfb_pkg::FUNC_DATA, 8'hFF, 8'hFF, 8'h00);
    send_request(cfb_pkg::FUNC_START, 8'hFF, 8'd0, 8'hFF);   // empty frame, checksum = type
    send_request(cfb_pkg::FUNC_START, 8'h00, 8'd0, 8'h00);
    send_request(cfb_pkg::FUNC_START, 8'h3C, 8'd255, 8'h00); // too long
    send_request(cfb_pkg::FUNC_START, 8'hC3, 8'd252, 8'hFF); // just over the buffer
    send_request(cfb_pkg::FUNC_START, 8'h00, 8'd1, 8'hFF);
    send_request(cfb_pkg::FUNC_START, 8'hFF, 8'd255, 8'h00); // open frame beats too long
    send_request(cfb_pkg::FUNC_START, 8'h11, 8'd0, 8'h00);
    send_request(cfb_pkg::FUNC_DATA, 8'h00, 8'h00, 8'hFF);   // closes the frame
    send_request(cfb_pkg::FUNC_START, 8'hF0, 8'd3, 8'h00);
    send_request(cfb_pkg::FUNC_DATA, 8'hFF, 8'hFF, 8'h80);   // sum wraps
    send_request(cfb_pkg::FUNC_DATA, 8'h00, 8'h00, 8'h7F);
    send_request(cfb_pkg::FUNC_DATA, 8'h5A, 8'hA5, 8'hFF);
    send_request(cfb_pkg::FUNC_START, 8'h5A, 8'd2, 8'h00);
    send_request(cfb_pkg::FUNC_DATA, 8'h00, 8'h00, 8'h00);
    send_request(cfb_pkg::FUNC_DATA, 8'h00, 8'h00, 8'hA5);

    program_headers(8'h00, 8'h00);
    run_phase();

    // hold off the drain while requests keep coming back to back
    program_headers(8'hFF, 8'hFF);
    tx_idle_on = 1'b0;
    hold_requests++;
    run_phase();

    // drain without gaps
    program_headers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    rx_idle_on = 1'b0;
    run_phase();

    program_headers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    tx_idle_on = 1'b1;
    run_phase();

    wait_drained();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
